// ===== rtl/fir17_pkg.sv =====
// Shared types, sizes and fixed-point coefficients of the 17-tap low-pass FIR.
`timescale 1ns / 1ps
package fir17_pkg;

  localparam int TAP_COUNT      = 17;
  localparam int COEF_FRAC_BITS = 15;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = COEF_FRAC_BITS + 1;
  localparam int PROD_W         = SAMPLE_W + COEF_W;
  localparam int ACC_W          = PROD_W + $clog2(TAP_COUNT);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // design taps in millionths, index k weights x[n-k]
  localparam int CoefMicro [TAP_COUNT] = '{
    -2102, 519, 14189, 10317, -37919, -60378, 63665, 299972, 425000,
    299972, 63665, -60378, -37919, 10317, 14189, 519, -2102
  };

  // round to nearest, ties away from zero
  function automatic coef_t coef_fixed(input int k);
    longint m;
    longint mag;
    longint scaled;
    m      = longint'(CoefMicro[k]);
    mag    = (m < 0) ? -m : m;
    scaled = ((mag <<< COEF_FRAC_BITS) + 64'sd500000) / 64'sd1000000;
    return (m < 0) ? coef_t'(-scaled) : coef_t'(scaled);
  endfunction

endpackage

// ===== rtl/fir17_cell.sv =====
// One tap of the transposed FIR chain: multiply-add into a partial-sum register.
`timescale 1ns / 1ps
module fir17_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  fir17_pkg::sample_t sample_i,
  input  fir17_pkg::coef_t   coef_i,
  input  fir17_pkg::acc_t    sum_i,
  output fir17_pkg::acc_t    sum_o
);
  import fir17_pkg::*;

  prod_t prod;
  acc_t  sum_d;
  acc_t  sum_q;

  assign prod  = prod_t'(sample_i) * prod_t'(coef_i);
  assign sum_d = ACC_W'(prod) + sum_i;
  assign sum_o = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

endmodule

// ===== rtl/fir17_out_stage.sv =====
// Output stage: scale by 2^-COEF_FRAC_BITS toward zero, saturate, hold for transfer.
`timescale 1ns / 1ps
module fir17_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  fir17_pkg::acc_t    acc_i,
  output logic               valid_o,
  input  logic               ready_i,
  output fir17_pkg::sample_t sample_o
);
  import fir17_pkg::*;

  localparam acc_t RoundBias = acc_t'((64'sd1 <<< COEF_FRAC_BITS) - 64'sd1);
  localparam acc_t SatMax    = acc_t'(32767);
  localparam acc_t SatMin    = acc_t'(-32768);

  acc_t    biased;
  acc_t    quot;
  sample_t sat;
  logic    load;
  logic    valid_d, valid_q;
  sample_t data_q;

  assign biased = acc_i[ACC_W-1] ? (acc_i + RoundBias) : acc_i;
  assign quot   = biased >>> COEF_FRAC_BITS;

  always_comb begin
    if (quot > SatMax) begin
      sat = sample_t'(SatMax);
    end else if (quot < SatMin) begin
      sat = sample_t'(SatMin);
    end else begin
      sat = quot[SAMPLE_W-1:0];
    end
  end

  assign ready_o  = !valid_q || ready_i;
  assign load     = valid_i && ready_o;
  assign valid_d  = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);
  assign valid_o  = valid_q;
  assign sample_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= sat;
    end
  end

endmodule

// ===== rtl/fir_lowpass_17tap_unit.sv =====
// Top level of the symmetric 17-tap low-pass FIR with a stream interface.
`timescale 1ns / 1ps
// Symmetric 17-tap low-pass FIR (3.4 kHz cutoff at 16 kHz) in transposed form.
// One sample is taken per clock while the output side keeps up; each transfer
// moves a row of 17 multiply-add cells one step, so the rate is set by that
// single multiply and add per cell. A taken sample's result is held in the
// chain's partial-sum register, then in the scale-and-saturate register,
// waiting in either while the output stalls. Coefficients are Q1.15, the sum
// is exact, and the output is the sum shifted right by 15 with truncation
// toward zero, saturated to 16 bits. Reset clears the filter history.
module fir_lowpass_17tap_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] sample_out
);
  import fir17_pkg::*;

  sample_t sample;
  acc_t    sum [TAP_COUNT+1];
  logic    accept;
  logic    stg_ready;
  logic    acc_valid_d, acc_valid_q;
  sample_t sample_out;

  assign sample         = sample_t'(s_axis_tdata);
  assign sum[TAP_COUNT] = '0;
  assign s_axis_tready  = !acc_valid_q || stg_ready;
  assign accept         = s_axis_tvalid && s_axis_tready;
  assign acc_valid_d    = accept ? 1'b1 : (stg_ready ? 1'b0 : acc_valid_q);

  for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
    localparam coef_t CoefK = coef_fixed(k);
    fir17_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (accept),
      .sample_i (sample),
      .coef_i   (CoefK),
      .sum_i    (sum[k+1]),
      .sum_o    (sum[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_valid_q <= 1'b0;
    end else begin
      acc_valid_q <= acc_valid_d;
    end
  end

  fir17_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (acc_valid_q),
    .ready_o  (stg_ready),
    .acc_i    (sum[0]),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .sample_o (sample_out)
  );

  assign m_axis_tdata = 16'(sample_out);

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> acc_valid_q)
    else $error("accepted sample did not reach the sum register");

  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_valid_q && !stg_ready) |=> (acc_valid_q && $stable(sum[0])))
    else $error("pending sum lost or changed while output stalled");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!acc_valid_q && !m_axis_tvalid) |-> s_axis_tready)
    else $error("empty pipeline refuses input");

  a_chain_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(sum[TAP_COUNT-1]))
    else $error("filter history moved without a transfer");
`endif

endmodule
